### design/kmd_pkg.sv
// Shared types and constants for the key matrix debounce scanner.
package kmd_pkg;

    localparam int unsigned LEVEL_W     = 8;   // column_levels width, caps the scanned columns
    localparam int unsigned ROW_W       = 3;
    localparam int unsigned KEY_W       = 6;
    localparam int unsigned CNT_W       = 8;
    localparam int unsigned KEY_CALC_W  = 8;   // row * COLS + col before truncation
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [CNT_W-1:0] THRESHOLD_RESET = 8'd5;

    // APB register map
    localparam logic REG_THRESHOLD = 1'b0;

    // One row sample that committed at least one key.
    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [LEVEL_W-1:0] ev_mask;   // columns that committed
        logic [LEVEL_W-1:0] press;     // sampled level per column, 1 = pressed
    } kmd_row_ev_t;

endpackage

### design/kmd_front.sv
// Front end: accepts row samples, runs per-key debounce and queues commit masks.
module kmd_front #(
    parameter int unsigned ROWS = 8,
    parameter int unsigned COLS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [kmd_pkg::ROW_W-1:0]          row_index,
    input  logic [kmd_pkg::LEVEL_W-1:0]        column_levels,
    input  logic [kmd_pkg::CNT_W-1:0]          threshold,
    output logic                               q_push,
    output kmd_pkg::kmd_row_ev_t               q_data,
    input  logic                               q_full
);
    import kmd_pkg::*;

    localparam int unsigned SCAN_COLS = (COLS < LEVEL_W) ? COLS : LEVEL_W;
    localparam int unsigned ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [SCAN_COLS-1:0] committed_reg [ROWS];
    logic [SCAN_COLS-1:0] candidate_reg [ROWS];
    logic [CNT_W-1:0]     count_reg     [ROWS][SCAN_COLS];

    logic [SCAN_COLS-1:0] committed_next;
    logic [SCAN_COLS-1:0] candidate_next;
    logic [CNT_W-1:0]     count_next    [SCAN_COLS];

    logic [SCAN_COLS-1:0] cur_com;
    logic [SCAN_COLS-1:0] cur_cand;
    logic [CNT_W-1:0]     cur_cnt       [SCAN_COLS];

    logic [4:0]           row_ext;
    logic [ROW_AW-1:0]    row_sel;
    logic                 row_ok;
    logic                 accept;
    logic [LEVEL_W-1:0]   ev_mask;
    logic [LEVEL_W-1:0]   press;

    assign full    = q_full;
    assign accept  = push && !q_full;
    assign row_ext = {2'b00, row_index};
    assign row_sel = row_ext[ROW_AW-1:0];
    assign row_ok  = row_ext < 5'(ROWS);

    assign cur_com  = committed_reg[row_sel];
    assign cur_cand = candidate_reg[row_sel];
    assign cur_cnt  = count_reg[row_sel];

    always_comb
    begin
        logic             pressed;
        logic [CNT_W-1:0] inc;
        ev_mask        = '0;
        press          = '0;
        committed_next = cur_com;
        candidate_next = cur_cand;
        for (int c = 0; c < SCAN_COLS; c++)
        begin
            pressed       = ~column_levels[c];
            inc           = cur_cnt[c] + 8'd1;
            count_next[c] = cur_cnt[c];
            press[c]      = pressed;
            if (pressed == cur_com[c])
            begin
                count_next[c] = '0;
            end
            else if (pressed == cur_cand[c])
            begin
                count_next[c] = inc;
                if (inc >= threshold)
                begin
                    committed_next[c] = pressed;
                    count_next[c]     = '0;
                    ev_mask[c]        = 1'b1;
                end
            end
            else
            begin
                candidate_next[c] = pressed;
                count_next[c]     = 8'd1;
            end
        end
    end

    assign q_push          = accept && row_ok && (ev_mask != '0);
    assign q_data.row      = row_index;
    assign q_data.ev_mask  = ev_mask;
    assign q_data.press    = press;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                committed_reg[r] <= '0;
                candidate_reg[r] <= '0;
                for (int c = 0; c < SCAN_COLS; c++)
                begin
                    count_reg[r][c] <= '0;
                end
            end
        end
        else if (accept && row_ok)
        begin
            committed_reg[row_sel] <= committed_next;
            candidate_reg[row_sel] <= candidate_next;
            count_reg[row_sel]     <= count_next;
        end
    end

endmodule

### design/kmd_queue.sv
// Small FIFO between the debounce front end and the event serializer.
module kmd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  kmd_pkg::kmd_row_ev_t  push_data,
    output logic                  full,
    input  logic                  pop,
    output kmd_pkg::kmd_row_ev_t  pop_data,
    output logic                  empty
);
    import kmd_pkg::*;

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    kmd_row_ev_t      mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full     = cnt_reg == (AW+1)'(QUEUE_DEPTH);
    assign empty    = cnt_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/kmd_back.sv
// Back end: walks each commit mask in column order and emits one event per cycle unless pop stalls it.
module kmd_back #(
    parameter int unsigned COLS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  kmd_pkg::kmd_row_ev_t       q_data,
    input  logic                       q_empty,
    output logic                       q_pop,
    output logic                       empty,
    input  logic                       pop,
    output logic [kmd_pkg::KEY_W-1:0]  key_index,
    output logic                       is_press,
    output logic                       last_event
);
    import kmd_pkg::*;

    logic                  cur_valid_reg, cur_valid_next;
    logic [ROW_W-1:0]      cur_row_reg, cur_row_next;
    logic [LEVEL_W-1:0]    cur_mask_reg, cur_mask_next;
    logic [LEVEL_W-1:0]    cur_press_reg, cur_press_next;

    logic                  out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]      key_reg;
    logic                  press_reg;
    logic                  last_reg;

    logic [2:0]            col;
    logic [LEVEL_W-1:0]    rem_mask;
    logic [KEY_CALC_W-1:0] key_full;
    logic                  emit;
    logic                  done;

    // lowest pending column
    always_comb
    begin
        col = '0;
        for (int i = LEVEL_W - 1; i >= 0; i--)
        begin
            if (cur_mask_reg[i])
            begin
                col = 3'(i);
            end
        end
    end

    assign rem_mask = cur_mask_reg & (cur_mask_reg - 1'b1);
    assign key_full = KEY_CALC_W'(cur_row_reg) * KEY_CALC_W'(COLS) + KEY_CALC_W'(col);
    assign emit     = cur_valid_reg && (!out_valid_reg || pop);
    assign done     = emit && (rem_mask == '0);
    assign q_pop    = !q_empty && (!cur_valid_reg || done);

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_row_next   = cur_row_reg;
        cur_mask_next  = cur_mask_reg;
        cur_press_next = cur_press_reg;
        if (emit)
        begin
            cur_mask_next = rem_mask;
            if (done)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            cur_row_next   = q_data.row;
            cur_mask_next  = q_data.ev_mask;
            cur_press_next = q_data.press;
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_row_reg   <= cur_row_next;
        cur_mask_reg  <= cur_mask_next;
        cur_press_reg <= cur_press_next;
        if (emit)
        begin
            key_reg   <= key_full[KEY_W-1:0];
            press_reg <= cur_press_reg[col];
            last_reg  <= rem_mask == '0;
        end
    end

    assign empty      = !out_valid_reg;
    assign key_index  = key_reg;
    assign is_press   = press_reg;
    assign last_event = last_reg;

endmodule

### design/key_matrix_debounce_scanner.sv
// Top level of the key matrix debounce scanner.
//
// Input queue: one row sample (row_index, column_levels) per transaction,
// taken when push is high and full is low. Column bit low = key pressed.
// Each key runs a counter debounce against debounce_threshold (APB register
// at address 0, reset 5); a key that commits produces one press or release event.
// Result queue: key_index, is_press, last_event are valid while empty is low;
// pop takes the event. Events of one sample come out in column order, the
// final one flagged with last_event.
// Throughput: a sample is taken every cycle while the two-entry commit queue has
// room; the serializer emits one event per cycle, one per committed key, while the
// output register is empty or popped. Samples that commit nothing, or name a row
// beyond ROWS, produce no transaction on the result side.
// First event path: commit queue, serializer sample register, output register.
// A stalled result side fills the output register and the commit queue, then
// raises full; no event is dropped.
// Reset clears all key state and both queues and loads the default threshold.
module key_matrix_debounce_scanner #(
    parameter int unsigned ROWS = 8,
    parameter int unsigned COLS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               push,
    output logic                               full,
    input  logic [kmd_pkg::ROW_W-1:0]          row_index,
    input  logic [kmd_pkg::LEVEL_W-1:0]        column_levels,
    output logic                               empty,
    input  logic                               pop,
    output logic [kmd_pkg::KEY_W-1:0]          key_index,
    output logic                               is_press,
    output logic                               last_event
);
    import kmd_pkg::*;

    logic [CNT_W-1:0] threshold_reg;
    logic             cfg_wr;
    kmd_row_ev_t      fq_data;
    kmd_row_ev_t      qb_data;
    logic             fq_push;
    logic             fq_full;
    logic             qb_pop;
    logic             qb_empty;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_THRESHOLD)
        begin
            prdata = {24'd0, threshold_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_wr)
        begin
            threshold_reg <= pwdata[CNT_W-1:0];
        end
    end

    kmd_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .row_index     (row_index),
        .column_levels (column_levels),
        .threshold     (threshold_reg),
        .q_push        (fq_push),
        .q_data        (fq_data),
        .q_full        (fq_full)
    );

    kmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fq_push),
        .push_data (fq_data),
        .full      (fq_full),
        .pop       (qb_pop),
        .pop_data  (qb_data),
        .empty     (qb_empty)
    );

    kmd_back #(
        .COLS (COLS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (qb_data),
        .q_empty    (qb_empty),
        .q_pop      (qb_pop),
        .empty      (empty),
        .pop        (pop),
        .key_index  (key_index),
        .is_press   (is_press),
        .last_event (last_event)
    );

endmodule

### tb/key_matrix_debounce_scanner_tb.sv
// Self-checking testbench for the key matrix debounce scanner: directed table, then random phases.
module key_matrix_debounce_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kmd_pkg::*;

    localparam int unsigned ROWS         = 8;
    localparam int unsigned COLS         = 8;
    localparam int unsigned NKEYS        = ROWS * COLS;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned PHASE_ITEMS  = 60;
    localparam int unsigned N_DIRECTED   = 23;
    localparam logic [2:0]  THRESHOLD_ADDR = {REG_THRESHOLD, 2'b00};

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             press;
        logic             last;
    } key_event_t;

    typedef enum logic {STEP_PUSH, STEP_SET_THRESHOLD} step_kind_t;

    typedef struct {
        step_kind_t         kind;
        logic [ROW_W-1:0]   row;
        logic [LEVEL_W-1:0] value;        // column levels, or threshold for a register write
        int                 typed_n;      // -1: predictor only
        logic [KEY_W-1:0]   typed_key;    // first event of the sample
        logic               typed_press;
    } step_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [2:0]          paddr         = '0;
    logic [31:0]         pwdata        = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                push          = 1'b0;
    logic                full;
    logic [ROW_W-1:0]    row_index     = '0;
    logic [LEVEL_W-1:0]  column_levels = '1;
    logic                empty;
    logic                pop           = 1'b0;
    logic [KEY_W-1:0]    key_index;
    logic                is_press;
    logic                last_event;

    // predicted debounce state
    logic                committed_lvl [NKEYS];
    logic                candidate_lvl [NKEYS];
    logic [CNT_W-1:0]    agree_cnt     [NKEYS];
    logic [CNT_W-1:0]    debounce_limit;

    key_event_t          pending_events [$];
    int                  mismatch_count = 0;
    int                  burst_left     = 0;

    step_t directed_steps [N_DIRECTED] = '{
        '{STEP_PUSH,          3'd0, 8'hFE,  0, 6'd0,  1'b0},
        '{STEP_PUSH,          3'd0, 8'hFE,  0, 6'd0,  1'b0},
        '{STEP_PUSH,          3'd0, 8'hFE,  0, 6'd0,  1'b0},
        '{STEP_PUSH,          3'd0, 8'hFE,  0, 6'd0,  1'b0},
        '{STEP_PUSH,          3'd0, 8'hFE,  1, 6'd0,  1'b1},
        // glitch back to the committed level clears the counts
        '{STEP_PUSH,          3'd2, 8'h00,  0, 6'd0,  1'b0},
        '{STEP_PUSH,          3'd2, 8'hFF,  0, 6'd0,  1'b0},
        '{STEP_PUSH,          3'd2, 8'h00,  0, 6'd0,  1'b0},
        // threshold one commits on the second agreeing read
        '{STEP_SET_THRESHOLD, 3'd0, 8'd1,  -1, 6'd0,  1'b0},
        '{STEP_PUSH,          3'd4, 8'h0F,  0, 6'd0,  1'b0},
        '{STEP_PUSH,          3'd4, 8'h0F,  4, 6'd36, 1'b1},
        // threshold zero: any agreeing read commits
        '{STEP_SET_THRESHOLD, 3'd0, 8'd0,  -1, 6'd0,  1'b0},
        '{STEP_PUSH,          3'd4, 8'hFF,  0, 6'd0,  1'b0},
        '{STEP_PUSH,          3'd4, 8'hFF,  4, 6'd36, 1'b0},
        // count built under a high threshold, then threshold lowered below it
        '{STEP_SET_THRESHOLD, 3'd0, 8'd20, -1, 6'd0,  1'b0},
        '{STEP_PUSH,          3'd7, 8'h00,  0, 6'd0,  1'b0},
        '{STEP_PUSH,          3'd7, 8'h00,  0, 6'd0,  1'b0},
        '{STEP_PUSH,          3'd7, 8'h00,  0, 6'd0,  1'b0},
        '{STEP_PUSH,          3'd7, 8'h00,  0, 6'd0,  1'b0},
        '{STEP_PUSH,          3'd7, 8'h00,  0, 6'd0,  1'b0},
        '{STEP_PUSH,          3'd7, 8'h00,  0, 6'd0,  1'b0},
        '{STEP_SET_THRESHOLD, 3'd0, 8'd4,  -1, 6'd0,  1'b0},
        '{STEP_PUSH,          3'd7, 8'h00,  8, 6'd56, 1'b1}
    };

    key_matrix_debounce_scanner dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .row_index     (row_index),
        .column_levels (column_levels),
        .empty         (empty),
        .pop           (pop),
        .key_index     (key_index),
        .is_press      (is_press),
        .last_event    (last_event)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Debounce one row sample; queues its events and returns how many there were.
    function automatic int debounce_row(input logic [ROW_W-1:0] row,
                                        input logic [LEVEL_W-1:0] levels,
                                        output key_event_t first_ev);
        key_event_t       row_events [$];
        int               key;
        logic             pressed;
        logic [CNT_W-1:0] cnt;
        first_ev = '0;
        if (int'(row) >= ROWS)
            return 0;
        for (int c = 0; c < COLS && c < LEVEL_W; c++)
        begin
            key = int'(row) * COLS + c;
            if (key >= NKEYS)
                break;
            pressed = ~levels[c];
            if (pressed == committed_lvl[key])
                agree_cnt[key] = '0;
            else if (pressed == candidate_lvl[key])
            begin
                cnt = agree_cnt[key] + 1'b1;
                agree_cnt[key] = cnt;
                if (cnt >= debounce_limit)
                begin
                    committed_lvl[key] = pressed;
                    agree_cnt[key] = '0;
                    row_events.push_back('{KEY_W'(key), pressed, 1'b0});
                end
            end
            else
            begin
                candidate_lvl[key] = pressed;
                agree_cnt[key] = CNT_W'(1);
            end
        end
        if (row_events.size() > 0)
        begin
            row_events[$].last = 1'b1;
            first_ev = row_events[0];
        end
        foreach (row_events[i])
            pending_events.push_back(row_events[i]);
        return row_events.size();
    endfunction

    // Offer one sample, wait for the transaction, then keep the burst/gap pattern going.
    task automatic offer_sample(input logic [ROW_W-1:0] row, input logic [LEVEL_W-1:0] levels,
                                output int n_ev, output key_event_t first_ev);
        int gap;
        push          <= 1'b1;
        row_index     <= row;
        column_levels <= levels;
        do
            @(posedge clk);
        while (full);
        n_ev = debounce_row(row, levels, first_ev);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 6);
            gap = $urandom_range(1, 8);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        if (push)
            push <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THRESHOLD_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= THRESHOLD_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_threshold(input logic [CNT_W-1:0] value);
        logic [31:0] rd;
        wait_idle();
        apb_write(32'(value));
        debounce_limit = value;
        apb_read(rd);
        if (rd !== 32'(value))
            flag_mismatch($sformatf("threshold read back %0d, wrote %0d", rd, value));
    endtask

    // Result side: check each transaction, stall on a pattern that cycles through modes.
    always @(posedge clk)
    begin : event_sink
        key_event_t want;
        int         stall_tick;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_events.size() == 0)
                    flag_mismatch($sformatf("event for key %0d with none expected", key_index));
                else
                begin
                    want = pending_events.pop_front();
                    if (key_index !== want.key)
                        flag_mismatch($sformatf("key_index %0d, expected %0d",
                                                key_index, want.key));
                    if (is_press !== want.press)
                        flag_mismatch($sformatf("is_press %b, expected %b for key %0d",
                                                is_press, want.press, want.key));
                    if (last_event !== want.last)
                        flag_mismatch($sformatf("last_event %b, expected %b for key %0d",
                                                last_event, want.last, want.key));
                end
            end
            stall_tick++;
            case ((stall_tick / 64) % 4)
                0:       pop <= 1'b1;
                1:       pop <= 1'($urandom_range(0, 1));
                2:       pop <= (stall_tick % 6 == 0);
                default: pop <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial
    begin : stimulus
        key_event_t         first_ev;
        int                 n_ev;
        int                 sent;
        int                 reps;
        logic [31:0]        rd;
        logic [ROW_W-1:0]   row;
        logic [LEVEL_W-1:0] pattern;
        logic [LEVEL_W-1:0] lv;
        logic [CNT_W-1:0]   phase_limits [4];

        phase_limits = '{8'd3, 8'd1, 8'd8, 8'd2};
        for (int k = 0; k < NKEYS; k++)
        begin
            committed_lvl[k] = 1'b0;
            candidate_lvl[k] = 1'b0;
            agree_cnt[k]     = '0;
        end
        debounce_limit = THRESHOLD_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_read(rd);
        if (rd !== 32'd5)
            flag_mismatch($sformatf("threshold after reset %0d, expected 5", rd));

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == STEP_SET_THRESHOLD)
                set_threshold(directed_steps[i].value);
            else
            begin
                offer_sample(directed_steps[i].row, directed_steps[i].value, n_ev, first_ev);
                if (directed_steps[i].typed_n >= 0)
                begin
                    if (n_ev != directed_steps[i].typed_n)
                        flag_mismatch($sformatf("step %0d: %0d events predicted, table says %0d",
                                                i, n_ev, directed_steps[i].typed_n));
                    else if (n_ev > 0 && (first_ev.key !== directed_steps[i].typed_key ||
                                          first_ev.press !== directed_steps[i].typed_press))
                        flag_mismatch($sformatf("step %0d: first event key %0d press %b",
                                                i, first_ev.key, first_ev.press));
                end
            end
        end

        // Mostly held patterns long enough to commit, some with a stray bit, plus noise.
        foreach (phase_limits[p])
        begin
            set_threshold(phase_limits[p]);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    row     = ROW_W'($urandom_range(0, ROWS - 1));
                    pattern = LEVEL_W'($urandom);
                    reps    = ((debounce_limit < 2) ? 2 : int'(debounce_limit))
                              + $urandom_range(0, 2);
                    repeat (reps)
                    begin
                        lv = pattern;
                        if ($urandom_range(0, 9) == 0)
                            lv[$urandom_range(0, LEVEL_W - 1)] ^= 1'b1;
                        offer_sample(row, lv, n_ev, first_ev);
                        sent++;
                    end
                end
                else
                begin
                    offer_sample(ROW_W'($urandom_range(0, ROWS - 1)), LEVEL_W'($urandom),
                                 n_ev, first_ev);
                    sent++;
                end
            end
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
design/kmd_pkg.sv
design/kmd_front.sv
design/kmd_queue.sv
design/kmd_back.sv
design/key_matrix_debounce_scanner.sv
tb/key_matrix_debounce_scanner_tb.sv
